@@ rtl/hklm_pkg.sv @@
// hklm_pkg: shared types, constants and matrix update functions
// for the held key list to matrix block; no dependencies
`default_nettype none

package hklm_pkg;

    localparam int LIST_DEPTH_DEF = 64;

    localparam int SYM_W    = 16;
    localparam int CODE_W   = 8;
    localparam int ENTRY_W  = SYM_W + CODE_W;
    localparam int MATRIX_W = 64;
    localparam int COUNT_W  = 7;

    localparam int SHIFT_BIT   = 56;
    localparam int CODE_SH_BIT = 6;
    localparam int CODE_NK_BIT = 7;

    typedef enum logic [1:0] {
        OP_PRESS   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_NOP     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_OUT
    } t_state;

    function automatic logic [MATRIX_W-1:0] apply_press(
        input logic [MATRIX_W-1:0] matrix,
        input logic [CODE_W-1:0]   code
    );
        logic [MATRIX_W-1:0] m;
        m = matrix;
        if (!code[CODE_NK_BIT]) begin
            m[code[5:0]]  = 1'b1;
            m[SHIFT_BIT]  = code[CODE_SH_BIT];
        end
        return m;
    endfunction

    function automatic logic [MATRIX_W-1:0] apply_release(
        input logic [MATRIX_W-1:0] matrix,
        input logic [CODE_W-1:0]   code
    );
        logic [MATRIX_W-1:0] m;
        m = matrix;
        if (!code[CODE_NK_BIT]) begin
            m[code[5:0]] = 1'b0;
            if (code[CODE_SH_BIT]) begin
                m[SHIFT_BIT] = 1'b0;
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

@@ rtl/hklm_ram.sv @@
// hklm_ram: generic single write port ram with one registered read port
// no dependencies
`default_nettype none

module hklm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/held_key_list_to_matrix.sv @@
// held_key_list_to_matrix: held key list in ram with a sequencer for search
// and compaction, plus the 64-bit key matrix; uses hklm_pkg and hklm_ram
//
// usage:
//   input transaction (i_valid / o_stall): operation, host symbol, key
//   position, shifted and no-key flag. o_stall is high from acceptance
//   until the result transaction has been taken.
//   output transaction (o_valid / i_stall): matrix, held count, list full.
//   exactly one result per input transaction.
// sequence:
//   clear and unused operation: straight from idle to the result.
//   press: a linear search over the held list, one entry per cycle through
//   the registered ram read port.
//   release: search up to the match, then compaction moves every later
//   entry down one place, one per cycle through the same port.
//   the next item is accepted the cycle after the result is taken.
// reset: list empty, matrix all released; the ram needs no clearing.
// stall: the result stays on the outputs unchanged until taken.
`default_nettype none

module held_key_list_to_matrix #(
    parameter int LIST_DEPTH = hklm_pkg::LIST_DEPTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [1:0]                     i_operation,
    input  wire logic [hklm_pkg::SYM_W-1:0]     i_host_symbol,
    input  wire logic [5:0]                     i_key_position,
    input  wire logic                           i_shifted,
    input  wire logic                           i_no_key,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic      [hklm_pkg::MATRIX_W-1:0]  o_matrix,
    output logic      [hklm_pkg::COUNT_W-1:0]   o_held_count,
    output logic                                o_list_full
);

    import hklm_pkg::*;

    localparam int AW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);

    t_state              r_state, n_state;
    t_op                 r_op, n_op;
    logic [SYM_W-1:0]    r_sym, n_sym;
    logic [CODE_W-1:0]   r_code, n_code;
    logic [CW-1:0]       r_idx, n_idx;
    logic [AW-1:0]       r_cmp_idx, n_cmp_idx;
    logic                r_pend, n_pend;
    logic [CW-1:0]       r_total, n_total;
    logic [MATRIX_W-1:0] r_matrix, n_matrix;
    logic                r_full, n_full;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic [CODE_W-1:0]   in_code;
    logic                hit;
    logic                more;

    hklm_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(LIST_DEPTH)
    ) u_list (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign in_code = i_no_key ? CODE_W'(1 << CODE_NK_BIT)
                              : {1'b0, i_shifted, i_key_position};
    assign hit  = r_pend && (ram_rdata[ENTRY_W-1 -: SYM_W] == r_sym);
    assign more = (r_idx < r_total);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pend   <= 1'b0;
            r_total  <= '0;
            r_matrix <= '0;
            r_full   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pend   <= n_pend;
            r_total  <= n_total;
            r_matrix <= n_matrix;
            r_full   <= n_full;
        end
        r_op      <= n_op;
        r_sym     <= n_sym;
        r_code    <= n_code;
        r_idx     <= n_idx;
        r_cmp_idx <= n_cmp_idx;
    end

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_sym     = r_sym;
        n_code    = r_code;
        n_idx     = r_idx;
        n_cmp_idx = r_cmp_idx;
        n_pend    = r_pend;
        n_total   = r_total;
        n_matrix  = r_matrix;
        n_full    = r_full;
        ram_we    = 1'b0;
        ram_waddr = r_total[AW-1:0];
        ram_wdata = {r_sym, r_code};

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op   = t_op'(i_operation);
                    n_sym  = i_host_symbol;
                    n_code = in_code;
                    n_idx  = '0;
                    n_pend = 1'b0;
                    n_full = 1'b0;
                    unique case (t_op'(i_operation))
                        OP_PRESS, OP_RELEASE: n_state = S_SEARCH;
                        OP_CLEAR: begin
                            n_matrix = '0;
                            n_state  = S_OUT;
                        end
                        OP_NOP: n_state = S_OUT;
                    endcase
                end
            end

            S_SEARCH: begin
                priority if (hit) begin
                    if (r_op == OP_PRESS) begin
                        n_matrix = apply_press(r_matrix, r_code);
                        n_state  = S_OUT;
                    end else begin
                        n_code  = ram_rdata[CODE_W-1:0];
                        n_idx   = CW'(r_cmp_idx) + 1'b1;
                        n_pend  = 1'b0;
                        n_state = S_SHIFT;
                    end
                end else if (more) begin
                    n_cmp_idx = r_idx[AW-1:0];
                    n_idx     = r_idx + 1'b1;
                    n_pend    = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (r_op == OP_PRESS) begin
                        if (r_total < CW'(LIST_DEPTH)) begin
                            ram_we  = 1'b1;
                            n_total = r_total + 1'b1;
                        end else begin
                            n_full = 1'b1;
                        end
                        n_matrix = apply_press(r_matrix, r_code);
                    end
                    n_state = S_OUT;
                end
            end

            S_SHIFT: begin
                if (r_pend) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_cmp_idx - 1'b1;
                    ram_wdata = ram_rdata;
                end
                priority if (more) begin
                    n_cmp_idx = r_idx[AW-1:0];
                    n_idx     = r_idx + 1'b1;
                    n_pend    = 1'b1;
                end else if (r_pend) begin
                    n_pend = 1'b0;
                end else begin
                    n_total  = r_total - 1'b1;
                    n_matrix = apply_release(r_matrix, r_code);
                    n_state  = S_OUT;
                end
            end

            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = (r_state == S_OUT);
    assign o_matrix     = r_matrix;
    assign o_held_count = COUNT_W'(r_total);
    assign o_list_full  = r_full;

endmodule

`default_nettype wire

@@ tb/sv/tb_held_key_list_to_matrix.sv @@
// tb_held_key_list_to_matrix: self-checking testbench for the held key list to matrix block
// tracks the held list and key matrix in a small scoreboard class; uses hklm_pkg and the rtl
module tb_held_key_list_to_matrix;
    timeunit 1ns;
    timeprecision 1ps;

    import hklm_pkg::*;

    localparam int HELD_DEPTH   = LIST_DEPTH_DEF;
    localparam int POOL_SIZE    = 96;
    localparam int RANDOM_ITEMS = 1600;
    localparam int CALM_ITEMS   = 200;
    localparam int DRAIN_CYCLES = 300;
    localparam int CYCLE_LIMIT  = 1_500_000;

    typedef struct {
        logic [SYM_W-1:0] sym;
        logic [5:0]       pos;
        logic             shifted;
        logic             no_key;
    } held_entry_t;

    typedef struct {
        logic [MATRIX_W-1:0] matrix;
        logic [COUNT_W-1:0]  count;
        logic                full;
    } matrix_result_t;

    typedef enum int {
        PH_MIXED,
        PH_FILL,
        PH_DRAIN,
        PH_NOISE
    } phase_kind_t;

    class key_matrix_tracker;
        held_entry_t         held_list[$];
        logic [MATRIX_W-1:0] key_bits;
        matrix_result_t      due_results[$];
        int                  fail_count;

        function new();
            key_bits   = '0;
            fail_count = 0;
        endfunction

        function int find_held(logic [SYM_W-1:0] sym);
            foreach (held_list[k]) begin
                if (held_list[k].sym == sym) begin
                    return k;
                end
            end
            return -1;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function void note_event(t_op op, logic [SYM_W-1:0] sym, logic [5:0] pos,
                                 logic shifted, logic no_key);
            matrix_result_t r;
            held_entry_t    e;
            int             idx;
            idx    = find_held(sym);
            r.full = 1'b0;
            case (op)
                OP_PRESS: begin
                    if (idx < 0) begin
                        if (held_list.size() < HELD_DEPTH) begin
                            e.sym     = sym;
                            e.pos     = pos;
                            e.shifted = shifted;
                            e.no_key  = no_key;
                            held_list.push_back(e);
                        end else begin
                            r.full = 1'b1;
                        end
                    end
                    if (!no_key) begin
                        key_bits[pos]       = 1'b1;
                        key_bits[SHIFT_BIT] = shifted;
                    end
                end
                OP_RELEASE: begin
                    if (idx >= 0) begin
                        e = held_list[idx];
                        held_list.delete(idx);
                        if (!e.no_key) begin
                            key_bits[e.pos] = 1'b0;
                            if (e.shifted) begin
                                key_bits[SHIFT_BIT] = 1'b0;
                            end
                        end
                    end
                end
                OP_CLEAR: begin
                    key_bits = '0;
                end
                default: begin
                end
            endcase
            r.matrix = key_bits;
            r.count  = COUNT_W'(held_list.size());
            due_results.push_back(r);
        endfunction

        function void check_result(logic [MATRIX_W-1:0] matrix, logic [COUNT_W-1:0] count,
                                   logic full);
            matrix_result_t want;
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result, matrix %h count %0d full %0b",
                         $time, matrix, count, full);
                fail_count++;
                return;
            end
            want = due_results.pop_front();
            if (matrix !== want.matrix) begin
                $display("%0t: matrix mismatch, expected %h, actual %h",
                         $time, want.matrix, matrix);
                fail_count++;
            end
            if (count !== want.count) begin
                $display("%0t: held_count mismatch, expected %0d, actual %0d",
                         $time, want.count, count);
                fail_count++;
            end
            if (full !== want.full) begin
                $display("%0t: list_full mismatch, expected %0b, actual %0b",
                         $time, want.full, full);
                fail_count++;
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [1:0]          i_operation;
    logic [SYM_W-1:0]    i_host_symbol;
    logic [5:0]          i_key_position;
    logic                i_shifted;
    logic                i_no_key;
    logic                o_valid;
    logic                i_stall;
    logic [MATRIX_W-1:0] o_matrix;
    logic [COUNT_W-1:0]  o_held_count;
    logic                o_list_full;

    key_matrix_tracker   board;
    logic [SYM_W-1:0]    sym_pool[POOL_SIZE];
    bit                  idle_on;
    int                  sent;
    int                  cycle_count = 0;

    held_key_list_to_matrix #(
        .LIST_DEPTH(HELD_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_host_symbol  (i_host_symbol),
        .i_key_position (i_key_position),
        .i_shifted      (i_shifted),
        .i_no_key       (i_no_key),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_matrix       (o_matrix),
        .o_held_count   (o_held_count),
        .o_list_full    (o_list_full)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_held_key_list_to_matrix failed");
            $finish;
        end
    end

    // result checked before the new transaction is noted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                board.check_result(o_matrix, o_held_count, o_list_full);
            end
            if (i_valid && !o_stall) begin
                board.note_event(t_op'(i_operation), i_host_symbol, i_key_position,
                                 i_shifted, i_no_key);
            end
        end
    end

    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 7) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    task automatic drive_event(t_op op, logic [SYM_W-1:0] sym, logic [5:0] pos,
                               logic shifted, logic no_key);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_operation    <= op;
        i_host_symbol  <= sym;
        i_key_position <= pos;
        i_shifted      <= shifted;
        i_no_key       <= no_key;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic wait_for_drain();
        i_valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (board.pending() != 0);
    endtask

    function automatic logic [SYM_W-1:0] pick_held();
        if (board.held_list.size() == 0) begin
            return sym_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        return board.held_list[$urandom_range(0, board.held_list.size() - 1)].sym;
    endfunction

    task automatic press_random(logic [SYM_W-1:0] sym);
        drive_event(OP_PRESS, sym, 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)),
                    $urandom_range(0, 4) == 0);
    endtask

    task automatic release_random(logic [SYM_W-1:0] sym);
        drive_event(OP_RELEASE, sym, 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
    endtask

    task automatic noise_event();
        logic [SYM_W-1:0] sym;
        sym = $urandom_range(0, 1) ? SYM_W'($urandom) : sym_pool[$urandom_range(0, POOL_SIZE - 1)];
        drive_event(t_op'($urandom_range(0, 3)), sym, 6'($urandom_range(0, 63)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic run_phase(phase_kind_t kind);
        int len;
        int base;
        int r;
        len  = (kind == PH_FILL) ? $urandom_range(80, 100) : $urandom_range(40, 120);
        base = $urandom_range(0, POOL_SIZE - 1);
        for (int k = 0; k < len; k++) begin
            r = $urandom_range(0, 99);
            case (kind)
                PH_FILL: begin
                    if (r < 90) press_random(sym_pool[(base + k) % POOL_SIZE]);
                    else if (r < 96) release_random(pick_held());
                    else noise_event();
                end
                PH_DRAIN: begin
                    if (r < 85) release_random(pick_held());
                    else if (r < 95) press_random(sym_pool[$urandom_range(0, POOL_SIZE - 1)]);
                    else noise_event();
                end
                PH_NOISE: begin
                    noise_event();
                end
                default: begin
                    if (r < 48) press_random(sym_pool[$urandom_range(0, POOL_SIZE - 1)]);
                    else if (r < 70) release_random(pick_held());
                    else if (r < 84) release_random(sym_pool[$urandom_range(0, POOL_SIZE - 1)]);
                    else if (r < 92) drive_event(OP_CLEAR, SYM_W'($urandom),
                                                 6'($urandom_range(0, 63)),
                                                 1'($urandom_range(0, 1)),
                                                 1'($urandom_range(0, 1)));
                    else noise_event();
                end
            endcase
        end
    endtask

    initial begin
        int phase;
        board          = new();
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_operation    = OP_NOP;
        i_host_symbol  = '0;
        i_key_position = '0;
        i_shifted      = 1'b0;
        i_no_key       = 1'b0;
        idle_on        = 1'b1;
        sent           = 0;
        phase          = 0;
        sym_pool[0]    = '0;
        sym_pool[1]    = '1;
        for (int k = 2; k < POOL_SIZE; k++) begin
            sym_pool[k] = SYM_W'($urandom);
        end
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed cases
        drive_event(OP_PRESS,   16'h0000, 6'd0,  1'b0, 1'b0);
        drive_event(OP_PRESS,   16'hFFFF, 6'd63, 1'b1, 1'b0);
        drive_event(OP_PRESS,   16'h1234, 6'd10, 1'b0, 1'b0);
        drive_event(OP_PRESS,   16'hFFFF, 6'd5,  1'b1, 1'b0);
        drive_event(OP_PRESS,   16'h00AA, 6'd33, 1'b1, 1'b1);
        drive_event(OP_RELEASE, 16'h5555, 6'd7,  1'b0, 1'b0);
        drive_event(OP_RELEASE, 16'h00AA, 6'd0,  1'b0, 1'b0);
        drive_event(OP_RELEASE, 16'hFFFF, 6'd0,  1'b0, 1'b0);
        drive_event(OP_NOP,     16'hBEEF, 6'd63, 1'b1, 1'b1);
        drive_event(OP_CLEAR,   16'h0000, 6'd0,  1'b0, 1'b0);
        drive_event(OP_PRESS,   16'h0001, 6'd56, 1'b0, 1'b0);
        drive_event(OP_RELEASE, 16'h0000, 6'd0,  1'b0, 1'b0);
        drive_event(OP_RELEASE, 16'h1234, 6'd0,  1'b0, 1'b0);
        drive_event(OP_RELEASE, 16'h0001, 6'd0,  1'b0, 1'b0);
        drive_event(OP_RELEASE, 16'h0001, 6'd0,  1'b0, 1'b0);
        drive_event(OP_PRESS,   16'hA5A5, 6'd42, 1'b1, 1'b0);
        drive_event(OP_PRESS,   16'h5A5A, 6'd21, 1'b0, 1'b0);
        drive_event(OP_CLEAR,   16'hFFFF, 6'd63, 1'b1, 1'b1);
        drive_event(OP_RELEASE, 16'hA5A5, 6'd0,  1'b0, 1'b0);
        drive_event(OP_RELEASE, 16'h5A5A, 6'd0,  1'b0, 1'b0);
        wait_for_drain();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            phase++;
            idle_on = (sent < RANDOM_ITEMS - CALM_ITEMS) && ($urandom_range(0, 3) != 0);
            if (phase % 4 == 0) begin
                wait_for_drain();
            end
            run_phase(phase_kind_t'($urandom_range(0, 3)));
        end

        i_valid <= 1'b0;
        while (board.pending() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (board.fail_count == 0 && board.pending() == 0) begin
            $display("tb_held_key_list_to_matrix passed");
        end else begin
            $display("tb_held_key_list_to_matrix failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/hklm_pkg.sv
rtl/hklm_ram.sv
rtl/held_key_list_to_matrix.sv
tb/sv/tb_held_key_list_to_matrix.sv
